/* hdl/assert_macros.svh */
// assertion helpers for the rtl files, included by mux_stream_deframer_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hdl/msd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

	// header constants
	localparam logic [15:0] MAGIC_WORD = 16'h33fc;
	localparam logic [7:0]  CMD_DATA   = 8'h00;
	localparam logic [7:0]  CMD_OPEN   = 8'h01;
	localparam logic [7:0]  CMD_CLOSE  = 8'h02;

	// result kinds
	localparam logic [2:0] KIND_DATA        = 3'd0;
	localparam logic [2:0] KIND_EMPTY       = 3'd1;
	localparam logic [2:0] KIND_STATUS      = 3'd2;
	localparam logic [2:0] KIND_BAD_MAGIC   = 3'd3;
	localparam logic [2:0] KIND_BAD_CHANNEL = 3'd4;

	// one received word
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
	} item_t;

	// one result word
	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] channel;
		logic [7:0] payload_byte;
		logic       packet_last;
		logic [7:0] remote_open_mask;
	} result_t;

endpackage

`default_nettype wire

/* hdl/msd_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module msd_parser #(
	parameter int CHANNELS = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	input  wire msd_pkg::item_t  item,
	output logic                 item_ready,
	input  wire logic [7:0]      local_mask,
	output logic                 res_valid,
	output msd_pkg::result_t     res,
	input  wire logic            res_ready
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_PAD,
		PH_DISCARD
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [2:0]       hcount_q;
	logic [55:0]      hdr_q;
	logic [15:0]      bytes_left_q, bytes_left_d;
	logic [7:0]       pad_left_q, pad_left_d;
	logic [2:0]       chan_q, chan_d;
	logic             deliver_q, deliver_d;
	logic [7:0]       remote_q, remote_d;
	logic             emit;
	msd_pkg::result_t res_d;
	logic             fire;

	// header fields, the last byte arrives with the incoming word
	logic [15:0] magic;
	logic [7:0]  cmd;
	logic [7:0]  pad;
	logic [7:0]  ch;
	logic [15:0] len;
	logic        ch_ok;
	logic        ch_open;
	logic [15:0] bl_dec;
	logic [7:0]  pad_dec;

	assign magic   = hdr_q[15:0];
	assign cmd     = hdr_q[31:24];
	assign pad     = hdr_q[39:32];
	assign ch      = hdr_q[47:40];
	assign len     = {item.rx_byte, hdr_q[55:48]};
	assign ch_ok   = ch < 8'(CHANNELS);
	assign ch_open = ch_ok && local_mask[ch[2:0]];
	assign bl_dec  = bytes_left_q - 16'd1;
	assign pad_dec = pad_left_q - 8'd1;

	// the result slot frees when empty or being taken
	assign item_ready = !res_valid || res_ready;
	assign fire       = item_valid && item_ready;

	// next state and result for one word
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		pad_left_d   = pad_left_q;
		chan_d       = chan_q;
		deliver_d    = deliver_q;
		remote_d     = remote_q;
		emit         = 1'b0;
		res_d        = '0;
		unique case (phase_q)
			PH_PAYLOAD: begin
				bytes_left_d = bl_dec;
				if (bl_dec == 16'd0) begin
					phase_d = (pad_left_q != 8'd0) ? PH_PAD : PH_HEADER;
				end
				if (deliver_q) begin
					emit               = 1'b1;
					res_d.kind         = msd_pkg::KIND_DATA;
					res_d.channel      = chan_q;
					res_d.payload_byte = item.rx_byte;
					res_d.packet_last  = (bl_dec == 16'd0);
				end
			end
			PH_PAD: begin
				pad_left_d = pad_dec;
				if (pad_dec == 8'd0) begin
					phase_d = PH_HEADER;
				end
			end
			PH_DISCARD: begin
				if (item.chunk_end) begin
					phase_d = PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (hcount_q == 3'd7) begin
					if (magic != msd_pkg::MAGIC_WORD) begin
						emit       = 1'b1;
						res_d.kind = msd_pkg::KIND_BAD_MAGIC;
						if (!item.chunk_end) begin
							phase_d = PH_DISCARD;
						end
					end else if (cmd == msd_pkg::CMD_DATA) begin
						chan_d       = ch[2:0];
						bytes_left_d = len;
						pad_left_d   = pad;
						deliver_d    = ch_open;
						if (len != 16'd0) begin
							phase_d = PH_PAYLOAD;
						end else if (pad != 8'd0) begin
							phase_d = PH_PAD;
						end
						if (!ch_ok) begin
							emit          = 1'b1;
							res_d.kind    = msd_pkg::KIND_BAD_CHANNEL;
							res_d.channel = ch[2:0];
						end else if (len == 16'd0 && ch_open) begin
							emit          = 1'b1;
							res_d.kind    = msd_pkg::KIND_EMPTY;
							res_d.channel = ch[2:0];
						end
					end else if (cmd == msd_pkg::CMD_OPEN || cmd == msd_pkg::CMD_CLOSE) begin
						chan_d        = ch[2:0];
						emit          = 1'b1;
						res_d.channel = ch[2:0];
						if (!ch_ok) begin
							res_d.kind = msd_pkg::KIND_BAD_CHANNEL;
						end else begin
							res_d.kind = msd_pkg::KIND_STATUS;
							if (cmd == msd_pkg::CMD_OPEN) begin
								remote_d = remote_q | (8'b1 << ch[2:0]);
							end else begin
								remote_d = remote_q & ~(8'b1 << ch[2:0]);
							end
						end
					end
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
		res_d.remote_open_mask = remote_d;
	end

	// parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hcount_q     <= 3'd0;
			hdr_q        <= '0;
			bytes_left_q <= 16'd0;
			pad_left_q   <= 8'd0;
			chan_q       <= 3'd0;
			deliver_q    <= 1'b0;
			remote_q     <= 8'd0;
			res_valid    <= 1'b0;
			res          <= '0;
		end else begin
			if (fire) begin
				phase_q      <= phase_d;
				bytes_left_q <= bytes_left_d;
				pad_left_q   <= pad_left_d;
				chan_q       <= chan_d;
				deliver_q    <= deliver_d;
				remote_q     <= remote_d;
				if (phase_q == PH_HEADER) begin
					hcount_q <= hcount_q + 3'd1;
					if (hcount_q != 3'd7) begin
						hdr_q[{hcount_q, 3'b000} +: 8] <= item.rx_byte;
					end
				end
			end
			if (fire && emit) begin
				res_valid <= 1'b1;
				res       <= res_d;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/mux_stream_deframer_core.sv */
// an accepted word passes the input register, then the parser result register
// throughput: one word per cycle via the single parser pass, unless out_ready stalls
// words that give no result still take their pass through the parser
// reset: arst_n is asynchronous, active low; clears parser state, remote bits and the open mask
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mux_stream_deframer_core #(
	parameter int CHANNELS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       chunk_end,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      kind,
	output logic [2:0]      channel,
	output logic [7:0]      payload_byte,
	output logic            packet_last,
	output logic [7:0]      remote_open_mask,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] local_open_mask
);

	logic             valid_s1;
	msd_pkg::item_t   item_s1;
	logic             prs_ready;
	logic [7:0]       mask_q;
	msd_pkg::result_t res;

	// open mask register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 8'd0;
		end else if (cfg_valid) begin
			mask_q <= local_open_mask;
		end
	end

	// input register stage
	assign in_ready = !valid_s1 || prs_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.rx_byte   <= rx_byte;
			item_s1.chunk_end <= chunk_end;
		end
	end

	msd_parser #(
		.CHANNELS(CHANNELS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(valid_s1),
		.item      (item_s1),
		.item_ready(prs_ready),
		.local_mask(mask_q),
		.res_valid (out_valid),
		.res       (res),
		.res_ready (out_ready)
	);

	assign kind             = res.kind;
	assign channel          = res.channel;
	assign payload_byte     = res.payload_byte;
	assign packet_last      = res.packet_last;
	assign remote_open_mask = res.remote_open_mask;

	// checks
	`ASSERT_IMPLIES(a_nondata_clean, clk, arst_n,
		out_valid && kind != msd_pkg::KIND_DATA, payload_byte == 8'd0 && packet_last == 1'b0,
		"non-data word carries payload")
	`ASSERT_IMPLIES(a_bad_magic_chan, clk, arst_n,
		out_valid && kind == msd_pkg::KIND_BAD_MAGIC, channel == 3'd0,
		"bad magic word with nonzero channel")
	`ASSERT_NEXT(a_s1_hold, clk, arst_n,
		valid_s1 && !prs_ready, valid_s1 && $stable(item_s1),
		"stalled input stage lost its word")

endmodule

`default_nettype wire
